// ===== hw/rtl/tnst_pkg.sv =====
package tnst_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int OP_W       = 2;
   localparam int SCORE_W    = 16;
   localparam int INITIALS_W = 24;
   localparam int INDEX_W    = 3;
   localparam int CHAR_W     = 8;

   // The initials field carries at most this many characters.
   localparam int MAX_TAG_CHARS = INITIALS_W / CHAR_W;

   // Character used to seed the initials of entry 0 after reset.
   localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;

   // Operation codes carried by a request transaction.
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } tnst_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } tnst_cmd_type;

endpackage

// ===== hw/rtl/tnst_if.sv =====
// Request channel: one operation on the score table per transaction.
interface tnst_req_if import tnst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [SCORE_W-1:0]    new_score;
   logic [INITIALS_W-1:0] new_initials;
   logic [INDEX_W-1:0]    entry_index;

   modport source (output valid, operation, new_score, new_initials, entry_index,
                   input ready);
   modport sink   (input valid, operation, new_score, new_initials, entry_index,
                   output ready);
endinterface

// Response channel: one result per request transaction.
interface tnst_rsp_if import tnst_pkg::*; #(parameter int RANK_W = 4) ();
   logic                  valid;
   logic                  ready;
   logic [RANK_W-1:0]     rank;
   logic                  qualified;
   logic [SCORE_W-1:0]    read_score;
   logic [INITIALS_W-1:0] read_initials;

   modport source (output valid, rank, qualified, read_score, read_initials,
                   input ready);
   modport sink   (input valid, rank, qualified, read_score, read_initials,
                   output ready);
endinterface

// ===== hw/rtl/tnst_controller.sv =====
module tnst_controller import tnst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output tnst_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      execute;

   // A request is taken only while no operation is in flight.
   assign req_ready = (state_ff == ST_IDLE) && !reset;

   // The operation completes once the output register is free or being emptied.
   assign execute = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = execute;
   assign rsp_valid   = rsp_valid_ff;

   // Next state and response valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (execute) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/tnst_datapath.sv =====
module tnst_datapath import tnst_pkg::*; #(
   parameter int ENTRIES   = 8,
   parameter int TAG_CHARS = 3,
   parameter int RANK_W    = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tnst_cmd_type          cmd,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [SCORE_W-1:0]    req_new_score,
   input  logic [INITIALS_W-1:0] req_new_initials,
   input  logic [INDEX_W-1:0]    req_entry_index,
   output logic [RANK_W-1:0]     rsp_rank,
   output logic                  rsp_qualified,
   output logic [SCORE_W-1:0]    rsp_read_score,
   output logic [INITIALS_W-1:0] rsp_read_initials
);

   localparam int TAG_BYTES = (TAG_CHARS < MAX_TAG_CHARS) ? TAG_CHARS : MAX_TAG_CHARS;
   localparam int TAG_W     = TAG_BYTES * CHAR_W;

   // Captured request.
   tnst_op_type          op_ff;
   logic [SCORE_W-1:0]   score_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [INDEX_W-1:0]   index_ff;

   // Row of table cells, best score in cell 0.
   logic [SCORE_W-1:0]   cell_score_ff [ENTRIES];
   logic [SCORE_W-1:0]   cell_score_in [ENTRIES];
   logic [TAG_W-1:0]     cell_tag_ff   [ENTRIES];
   logic [TAG_W-1:0]     cell_tag_in   [ENTRIES];

   // Registered response payload.
   logic [RANK_W-1:0]     rank_ff;
   logic                  qualified_ff;
   logic [SCORE_W-1:0]    read_score_ff;
   logic [INITIALS_W-1:0] read_initials_ff;

   logic [ENTRIES-1:0]   below;
   logic [RANK_W-1:0]    rank_c;
   logic                 qualified_c;
   logic [SCORE_W-1:0]   rd_score_c;
   logic [TAG_W-1:0]     rd_tag_c;
   logic                 do_insert;

   // Every cell compares its score with the new score at once.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         below[i] = cell_score_ff[i] < score_ff;
      end
   end

   // The first cell that is beaten gives the rank; none beaten means ENTRIES.
   always_comb begin
      rank_c = RANK_W'(ENTRIES);
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (below[i]) begin
            rank_c = RANK_W'(i);
         end
      end
   end

   assign qualified_c = |below;
   assign do_insert   = cmd.execute && (op_ff == OP_INSERT);

   // Each beaten cell takes the new entry if it is the first one beaten,
   // otherwise the entry of its upper neighbor.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_score_in[i] = (do_insert && below[i]) ? score_ff : cell_score_ff[i];
         assign cell_tag_in[i]   = (do_insert && below[i]) ? tag_ff   : cell_tag_ff[i];
      end else begin : g_body
         always_comb begin
            cell_score_in[i] = cell_score_ff[i];
            cell_tag_in[i]   = cell_tag_ff[i];
            if (do_insert && below[i]) begin
               if (below[i-1]) begin
                  cell_score_in[i] = cell_score_ff[i-1];
                  cell_tag_in[i]   = cell_tag_ff[i-1];
               end else begin
                  cell_score_in[i] = score_ff;
                  cell_tag_in[i]   = tag_ff;
               end
            end
         end
      end
   end

   // Read select; an index past the table reads as zero.
   always_comb begin
      rd_score_c = '0;
      rd_tag_c   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (32'(index_ff) == i) begin
            rd_score_c = cell_score_ff[i];
            rd_tag_c   = cell_tag_ff[i];
         end
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= tnst_op_type'(req_operation);
         score_ff <= req_new_score;
         tag_ff   <= req_new_initials[TAG_W-1:0];
         index_ff <= req_entry_index;
      end
   end

   // Table cells; entry i resets to score zero and initials all 'A'+i.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            cell_score_ff[i] <= '0;
            cell_tag_ff[i]   <= {TAG_BYTES{CHAR_W'(int'(CHAR_A) + i)}};
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            cell_score_ff[i] <= cell_score_in[i];
            cell_tag_ff[i]   <= cell_tag_in[i];
         end
      end
   end

   // Response payload, loaded when the operation completes.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         case (op_ff) inside
            OP_INSERT, OP_QUERY: begin
               rank_ff          <= rank_c;
               qualified_ff     <= qualified_c;
               read_score_ff    <= '0;
               read_initials_ff <= '0;
            end
            OP_READ: begin
               rank_ff          <= '0;
               qualified_ff     <= 1'b0;
               read_score_ff    <= rd_score_c;
               read_initials_ff <= INITIALS_W'(rd_tag_c);
            end
            default: begin
               rank_ff          <= '0;
               qualified_ff     <= 1'b0;
               read_score_ff    <= '0;
               read_initials_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_rank          = rank_ff;
   assign rsp_qualified     = qualified_ff;
   assign rsp_read_score    = read_score_ff;
   assign rsp_read_initials = read_initials_ff;

endmodule

// ===== hw/rtl/top_n_sorted_score_table.sv =====
// Top-N sorted score table.
// Holds ENTRIES entries, each a 16-bit score with packed initials, in
// descending score order with the best entry at position 0.
// The request channel carries one operation per transaction: insert a score,
// read the entry at an index, or query the rank a score would take.
// Every request yields exactly one transaction on the response channel.
// Response valid rises after the accepted request has moved the controller into
// the EXEC state and the response register has been loaded there.
// One operation is in flight at a time, so no new request is taken until the
// last one completes; the request port drops ready in the EXEC state, which ends
// when the table row is compared, shifted and the response register is loaded.
// All entries are compared in parallel and shifted in the cycle the operation completes.
// When the receiver stalls, the response waits in its output register while
// one more request is accepted; that request then waits until the register
// is freed, and no further request is taken.
// Reset is synchronous: every score becomes zero, entry i gets all initials
// 'A'+i, and no response is pending.
module top_n_sorted_score_table import tnst_pkg::*; #(
   parameter int ENTRIES   = 8,
   parameter int TAG_CHARS = 3,
   parameter int RANK_W    = $clog2(ENTRIES + 1)
) (
   input  logic       clock,
   input  logic       reset,
   tnst_req_if.sink   req_chan,
   tnst_rsp_if.source rsp_chan
);

   tnst_cmd_type cmd;

   tnst_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   tnst_datapath #(
      .ENTRIES   (ENTRIES),
      .TAG_CHARS (TAG_CHARS),
      .RANK_W    (RANK_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_operation     (req_chan.operation),
      .req_new_score     (req_chan.new_score),
      .req_new_initials  (req_chan.new_initials),
      .req_entry_index   (req_chan.entry_index),
      .rsp_rank          (rsp_chan.rank),
      .rsp_qualified     (rsp_chan.qualified),
      .rsp_read_score    (rsp_chan.read_score),
      .rsp_read_initials (rsp_chan.read_initials)
   );

endmodule

// ===== hw/rtl/tnst_checker.sv =====
module tnst_checker import tnst_pkg::*; #(
   parameter int ENTRIES = 8,
   parameter int RANK_W  = 4
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [RANK_W-1:0]     rsp_rank,
   input logic                  rsp_qualified,
   input logic [SCORE_W-1:0]    rsp_read_score,
   input logic [INITIALS_W-1:0] rsp_read_initials
);

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Only one operation is in flight: an accepted request blocks the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an operation is in flight");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rank) &&
         $stable(rsp_qualified) && $stable(rsp_read_score) && $stable(rsp_read_initials)))
      else $error("stalled response changed");

   // Rank and qualified agree: a qualifying score lands inside the table,
   // a nonzero rank without qualification is the not-qualified rank.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_qualified && (32'(rsp_rank) < ENTRIES)) ||
                     (!rsp_qualified && (rsp_rank == '0 || 32'(rsp_rank) == ENTRIES))))
      else $error("rank and qualified disagree");

   // Rank results and read results never share one response; checked on qualifying ranks.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_qualified) |-> (rsp_read_score == '0 && rsp_read_initials == '0))
      else $error("read fields set on a rank result");

endmodule

bind top_n_sorted_score_table tnst_checker #(
   .ENTRIES (ENTRIES),
   .RANK_W  (RANK_W)
) u_tnst_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_rank          (rsp_chan.rank),
   .rsp_qualified     (rsp_chan.qualified),
   .rsp_read_score    (rsp_chan.read_score),
   .rsp_read_initials (rsp_chan.read_initials)
);
